// File: rtl/gasp_pkg.sv
// shared types, codes and widths for the glyph atlas shelf packer
package gasp_pkg;

  // default geometry
  localparam int PAGE_SIDE_DEF = 512;
  localparam int MAX_PAGES_DEF = 8;

  // fixed field widths
  localparam int LH_W   = 10;
  localparam int DIM_W  = 10;
  localparam int PAGE_W = 3;
  localparam int OFS_W  = 9;
  localparam int STAT_W = 3;

  // register file
  localparam int                  SHELF_H_RST     = 16;
  localparam logic                REG_IDX_SHELF_H = 1'b0;

  // opcodes
  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_PLACED    = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_TOO_TALL  = 3'd2,
    ST_OVERSIZE  = 3'd3,
    ST_EXHAUSTED = 3'd4,
    ST_CLEARED   = 3'd5
  } status_e;

  // place request travelling down the cell chain
  typedef struct packed {
    logic              valid;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic              found;
    logic [PAGE_W-1:0] page;
    logic [OFS_W-1:0]  ofs_x;
    logic [OFS_W-1:0]  ofs_y;
  } req_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic             clear;
    logic             open;
    logic [DIM_W-1:0] width;
  } cctl_t;

endpackage

// File: rtl/glyph_atlas_shelf_packer.sv
// top level: request checks, cell chain, page opening and result register
//
// Shelf packer for glyph atlas pages. Each of the MAX_PAGES cells holds one page's
// cursor; a place request walks the chain one cell per cycle and the first open page
// that fits takes it, otherwise the next page is opened at the chain tail. A place
// beat that reaches the scan walks the whole cell chain before the next beat can be
// accepted; clear beats and rejected glyphs skip the scan and go straight to the
// done state. The result register lets a new beat be accepted
// while the previous result is still stalled. The shelf height register sits at byte
// address 0 of the APB port and must only be written while the block is idle.
module glyph_atlas_shelf_packer import gasp_pkg::*; #(
  parameter int PAGE_SIDE = PAGE_SIDE_DEF,
  parameter int MAX_PAGES = MAX_PAGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              opcode_i,
  input  logic [DIM_W-1:0]  glyph_width_i,
  input  logic [DIM_W-1:0]  glyph_height_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [PAGE_W-1:0] page_index_o,
  output logic [OFS_W-1:0]  offset_x_o,
  output logic [OFS_W-1:0]  offset_y_o,
  output logic [STAT_W-1:0] status_o
);

  localparam int PO_W = $clog2(MAX_PAGES + 1);
  localparam int SW   = (($clog2(PAGE_SIDE + 1) > DIM_W) ? $clog2(PAGE_SIDE + 1) : DIM_W) + 1;
  localparam logic [SW-1:0] PS_S = SW'(PAGE_SIDE);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [LH_W-1:0]   shelf_h_q;
  logic [PO_W-1:0]   pages_open_q, pages_open_d;

  logic [PAGE_W-1:0] res_page_q, res_page_d;
  logic [OFS_W-1:0]  res_x_q, res_x_d;
  logic [OFS_W-1:0]  res_y_q, res_y_d;
  status_e           res_stat_q, res_stat_d;

  logic              out_valid_q, out_valid_d;
  logic [PAGE_W-1:0] out_page_q;
  logic [OFS_W-1:0]  out_x_q, out_y_q;
  logic [STAT_W-1:0] out_stat_q;

  logic              accept, cfg_write, load_out, new_page;
  status_e           early_stat;
  logic              is_place;

  req_t              chain [MAX_PAGES+1];
  cctl_t             cell_ctl [MAX_PAGES];
  logic [MAX_PAGES-1:0] open_vec;
  logic [MAX_PAGES:0]   chain_vld;
  req_t              tail;

  // config register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shelf_h_q <= LH_W'(SHELF_H_RST);
    end else if (cfg_write && paddr[2] == REG_IDX_SHELF_H) begin
      shelf_h_q <= pwdata[LH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_IDX_SHELF_H) begin
      prdata = 32'(shelf_h_q);
    end
  end

  // request checks ahead of the scan
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    is_place   = 1'b0;
    early_stat = ST_PLACED;
    priority if (opcode_i == OP_CLEAR) begin
      early_stat = ST_CLEARED;
    end else if (glyph_width_i == '0 || glyph_height_i == '0) begin
      early_stat = ST_EMPTY;
    end else if (glyph_height_i > shelf_h_q) begin
      early_stat = ST_TOO_TALL;
    end else if (SW'(glyph_width_i) > PS_S || SW'(glyph_height_i) > PS_S) begin
      early_stat = ST_OVERSIZE;
    end else begin
      is_place = 1'b1;
    end
  end

  // chain head
  always_comb begin
    chain[0]        = '0;
    chain[0].valid  = accept && is_place;
    chain[0].width  = glyph_width_i;
    chain[0].height = glyph_height_i;
  end

  assign tail     = chain[MAX_PAGES];
  assign new_page = (state_q == S_SCAN) && tail.valid && !tail.found
                    && (pages_open_q != PO_W'(MAX_PAGES));

  // per-cell clear and open strobes
  always_comb begin
    for (int i = 0; i < MAX_PAGES; i++) begin
      cell_ctl[i].clear = accept && (opcode_i == OP_CLEAR);
      cell_ctl[i].open  = new_page && (pages_open_q == PO_W'(i));
      cell_ctl[i].width = tail.width;
    end
  end

  // page cells
  for (genvar g = 0; g < MAX_PAGES; g++) begin : g_cell
    gasp_cell #(
      .PAGE_SIDE (PAGE_SIDE),
      .CELL_IDX  (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shelf_h_i (shelf_h_q),
      .ctl_i     (cell_ctl[g]),
      .req_i     (chain[g]),
      .req_o     (chain[g+1]),
      .open_o    (open_vec[g])
    );
  end

  for (genvar g = 0; g <= MAX_PAGES; g++) begin : g_vld
    assign chain_vld[g] = chain[g].valid;
  end

  // sequencer
  assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    pages_open_d = pages_open_q;
    res_page_d   = res_page_q;
    res_x_d      = res_x_q;
    res_y_d      = res_y_q;
    res_stat_d   = res_stat_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_page_d = '0;
          res_x_d    = '0;
          res_y_d    = '0;
          res_stat_d = early_stat;
          if (opcode_i == OP_CLEAR) begin
            pages_open_d = '0;
          end
          state_d = is_place ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (tail.valid) begin
          state_d = S_DONE;
          if (tail.found) begin
            res_page_d = tail.page;
            res_x_d    = tail.ofs_x;
            res_y_d    = tail.ofs_y;
            res_stat_d = ST_PLACED;
          end else if (new_page) begin
            res_page_d   = PAGE_W'(pages_open_q);
            res_x_d      = '0;
            res_y_d      = '0;
            res_stat_d   = ST_PLACED;
            pages_open_d = pages_open_q + PO_W'(1);
          end else begin
            res_page_d = '0;
            res_x_d    = '0;
            res_y_d    = '0;
            res_stat_d = ST_EXHAUSTED;
          end
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pages_open_q <= '0;
    end else begin
      state_q      <= state_d;
      pages_open_q <= pages_open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_page_q <= res_page_d;
    res_x_q    <= res_x_d;
    res_y_q    <= res_y_d;
    res_stat_q <= res_stat_d;
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_page_q <= res_page_q;
      out_x_q    <= res_x_q;
      out_y_q    <= res_y_q;
      out_stat_q <= res_stat_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign page_index_o = out_page_q;
  assign offset_x_o   = out_x_q;
  assign offset_y_o   = out_y_q;
  assign status_o     = out_stat_q;

  // checks
  a_pages_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pages_open_q <= PO_W'(MAX_PAGES))
    else $error("open page count above page limit");

  a_open_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(open_vec) == int'(pages_open_q))
    else $error("cell open flags disagree with open page count");

  a_one_in_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(chain_vld) <= 1)
    else $error("more than one beat in the cell chain");

  a_tail_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> state_q == S_SCAN)
    else $error("chain tail beat outside scan");

  a_zero_unplaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_PLACED) |->
      (page_index_o == '0 && offset_x_o == '0 && offset_y_o == '0))
    else $error("unplaced result carries nonzero position");

endmodule

// File: rtl/gasp_cell.sv
// one atlas page: cursor state, fit test and placement, one chain hop per cycle
module gasp_cell import gasp_pkg::*; #(
  parameter int PAGE_SIDE = PAGE_SIDE_DEF,
  parameter int CELL_IDX  = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [LH_W-1:0] shelf_h_i,
  input  cctl_t           ctl_i,
  input  req_t            req_i,
  output req_t            req_o,
  output logic            open_o
);

  localparam int CW = $clog2(PAGE_SIDE + 1);
  localparam int SW = ((CW > DIM_W) ? CW : DIM_W) + 2;
  localparam logic [SW-1:0] PS_S = SW'(PAGE_SIDE);

  logic          open_q, open_d;
  logic [CW-1:0] cx_q, cx_d;
  logic [CW-1:0] cy_q, cy_d;
  req_t          req_q, req_d;

  logic [SW-1:0] cx_s, cy_s, w_s, h_s, lh_s;
  logic          same_shelf, next_shelf, take, move;
  logic [CW-1:0] shelf_y;

  // fit test against this page's cursor
  always_comb begin
    cx_s       = SW'(cx_q);
    cy_s       = SW'(cy_q);
    w_s        = SW'(req_i.width);
    h_s        = SW'(req_i.height);
    lh_s       = SW'(shelf_h_i);
    same_shelf = (cy_s + h_s < PS_S) && (cx_s + w_s < PS_S);
    next_shelf = (cy_s + lh_s + h_s < PS_S) && (w_s < PS_S);
    take       = req_i.valid && !req_i.found && open_q && (same_shelf || next_shelf);
    move       = (cx_s + w_s > PS_S);
    shelf_y    = CW'(cy_s + lh_s);
  end

  // cursor update and forwarded beat
  always_comb begin
    open_d = open_q;
    cx_d   = cx_q;
    cy_d   = cy_q;
    req_d  = req_i;
    priority if (ctl_i.clear) begin
      open_d = 1'b0;
      cx_d   = '0;
      cy_d   = '0;
    end else if (ctl_i.open) begin
      open_d = 1'b1;
      cx_d   = CW'(ctl_i.width);
      cy_d   = '0;
    end else if (take) begin
      req_d.found = 1'b1;
      req_d.page  = PAGE_W'(CELL_IDX);
      if (move) begin
        cx_d        = CW'(req_i.width);
        cy_d        = shelf_y;
        req_d.ofs_x = '0;
        req_d.ofs_y = OFS_W'(shelf_y);
      end else begin
        cx_d        = CW'(cx_s + w_s);
        req_d.ofs_x = OFS_W'(cx_q);
        req_d.ofs_y = OFS_W'(cy_q);
      end
    end
  end

  // state and hop register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      cx_q   <= '0;
      cy_q   <= '0;
      req_q  <= '0;
    end else begin
      open_q <= open_d;
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      req_q  <= req_d;
    end
  end

  assign req_o  = req_q;
  assign open_o = open_q;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the glyph atlas shelf packer
module tb_top;
  import gasp_pkg::*;

  // one request beat and one expected result beat
  typedef struct {
    logic             op;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } glyph_req_t;

  typedef struct {
    logic [PAGE_W-1:0] page;
    logic [OFS_W-1:0]  ofs_x;
    logic [OFS_W-1:0]  ofs_y;
    status_e           status;
  } placement_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              opcode_i = OP_PLACE;
  logic [DIM_W-1:0]  glyph_width_i = '0;
  logic [DIM_W-1:0]  glyph_height_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [PAGE_W-1:0] page_index_o;
  logic [OFS_W-1:0]  offset_x_o;
  logic [OFS_W-1:0]  offset_y_o;
  logic [STAT_W-1:0] status_o;

  glyph_atlas_shelf_packer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .glyph_width_i  (glyph_width_i),
    .glyph_height_i (glyph_height_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .page_index_o   (page_index_o),
    .offset_x_o     (offset_x_o),
    .offset_y_o     (offset_y_o),
    .status_o       (status_o)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // packer state mirror
  int unsigned shelf_h = SHELF_H_RST;
  int unsigned pages_open = 0;
  int unsigned page_col [MAX_PAGES_DEF];
  int unsigned page_row [MAX_PAGES_DEF];

  glyph_req_t  glyph_backlog [$];
  placement_t  expected_placements [$];
  int unsigned mismatch_count = 0;
  bit          beat_taken = 1'b0;
  bit          no_gaps = 1'b0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  // shelf packing of one request against the mirrored pages
  function automatic placement_t place_glyph(glyph_req_t g);
    placement_t  r;
    int unsigned w;
    int unsigned h;
    int unsigned p;
    bit          found;
    r = '{page: '0, ofs_x: '0, ofs_y: '0, status: ST_PLACED};
    w = g.width;
    h = g.height;
    p = 0;
    found = 1'b0;
    if (g.op == OP_CLEAR) begin
      pages_open = 0;
      foreach (page_col[i]) begin
        page_col[i] = 0;
        page_row[i] = 0;
      end
      r.status = ST_CLEARED;
    end else if (w == 0 || h == 0) begin
      r.status = ST_EMPTY;
    end else if (h > shelf_h) begin
      r.status = ST_TOO_TALL;
    end else if (w > PAGE_SIDE_DEF || h > PAGE_SIDE_DEF) begin
      r.status = ST_OVERSIZE;
    end else begin
      // first open page where it fits on this shelf or the next one
      while (p < pages_open && !found) begin
        if ((page_row[p] + h < PAGE_SIDE_DEF && page_col[p] + w < PAGE_SIDE_DEF) ||
            (page_row[p] + shelf_h + h < PAGE_SIDE_DEF && w < PAGE_SIDE_DEF)) begin
          found = 1'b1;
        end else begin
          p++;
        end
      end
      if (!found) begin
        if (pages_open >= MAX_PAGES_DEF) begin
          r.status = ST_EXHAUSTED;
        end else begin
          p = pages_open;
          page_col[p] = 0;
          page_row[p] = 0;
          pages_open++;
          found = 1'b1;
        end
      end
      if (found) begin
        if (page_col[p] + w > PAGE_SIDE_DEF) begin
          page_col[p] = 0;
          page_row[p] += shelf_h;
        end
        r.page  = PAGE_W'(p);
        r.ofs_x = OFS_W'(page_col[p]);
        r.ofs_y = OFS_W'(page_row[p]);
        page_col[p] += w;
        r.status = ST_PLACED;
      end
    end
    return r;
  endfunction

  // mostly well-formed places, some clears, rejects and raw noise
  function automatic glyph_req_t random_glyph();
    glyph_req_t  g;
    int unsigned roll;
    int unsigned h_max;
    roll = $urandom_range(0, 99);
    h_max = (shelf_h > PAGE_SIDE_DEF) ? PAGE_SIDE_DEF : shelf_h;
    g.op = OP_PLACE;
    g.width = DIM_W'($urandom);
    g.height = DIM_W'($urandom);
    if (roll < 2) begin
      g.op = OP_CLEAR;
    end else if (roll < 6) begin
      g.width = '0;
    end else if (roll < 9) begin
      g.height = '0;
    end else if (roll < 13) begin
      g.height = DIM_W'($urandom_range(h_max, 1023));
    end else if (roll < 20) begin
      g.op = OP_PLACE;
    end else begin
      g.height = DIM_W'($urandom_range(1, h_max));
      if ($urandom_range(0, 19) == 0)
        g.width = DIM_W'(PAGE_SIDE_DEF);
      else if ($urandom_range(0, 1) == 0)
        g.width = DIM_W'($urandom_range(1, 64));
      else
        g.width = DIM_W'($urandom_range(65, PAGE_SIDE_DEF));
    end
    return g;
  endfunction

  // request accept and result check at the rising edge
  always @(posedge clk_i) begin
    placement_t exp_r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_placements.push_back(place_glyph('{op: opcode_i, width: glyph_width_i,
                                                  height: glyph_height_i}));
      beat_taken = 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_placements.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: page %0d x %0d y %0d status %0d",
                   page_index_o, offset_x_o, offset_y_o, status_o);
      end else begin
        exp_r = expected_placements.pop_front();
        if (page_index_o !== exp_r.page || offset_x_o !== exp_r.ofs_x ||
            offset_y_o !== exp_r.ofs_y || status_o !== exp_r.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result mismatch: exp page %0d x %0d y %0d status %0d,",
                      " got page %0d x %0d y %0d status %0d"},
                     exp_r.page, exp_r.ofs_x, exp_r.ofs_y, exp_r.status,
                     page_index_o, offset_x_o, offset_y_o, status_o);
        end
      end
    end
  end

  // request driver fed from the backlog
  always @(negedge clk_i) begin
    glyph_req_t g;
    if (!in_valid_i || beat_taken) begin
      beat_taken = 1'b0;
      if (glyph_backlog.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 26)) begin
        g = glyph_backlog.pop_front();
        in_valid_i     <= 1'b1;
        opcode_i       <= g.op;
        glyph_width_i  <= g.width;
        glyph_height_i <= g.height;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and a long hold-off on request
  always @(negedge clk_i) begin
    if (holds_served != holds_asked) begin
      holds_served = holds_asked;
      hold_left = 300;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !no_gaps && ($urandom_range(0, 99) < 26);
    end
  end

  // wait until every request is sent and every result has come back
  task automatic wait_drained();
    while (glyph_backlog.size() != 0 || in_valid_i || expected_placements.size() != 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // apb write of the shelf height followed by a read back
  task automatic write_shelf_h(int unsigned value);
    logic [31:0] rd;
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(REG_IDX_SHELF_H) << 2;
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    shelf_h = value & 32'h3FF;
    if (rd !== 32'(shelf_h)) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("shelf height read back: exp %0d got %0d", shelf_h, rd);
    end
  endtask

  task automatic push_glyph(logic op, int unsigned w, int unsigned h);
    glyph_backlog.push_back('{op: op, width: DIM_W'(w), height: DIM_W'(h)});
  endtask

  task automatic random_phase(int unsigned lh, int unsigned count);
    write_shelf_h(lh);
    repeat (count) glyph_backlog.push_back(random_glyph());
    wait_drained();
  endtask

  // stimulus
  initial begin
    foreach (page_col[i]) begin
      page_col[i] = 0;
      page_row[i] = 0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: rejects, full-width pages until exhausted, strict edge, clears
    push_glyph(OP_CLEAR, 1023, 1023);
    push_glyph(OP_PLACE, 0, 5);
    push_glyph(OP_PLACE, 5, 0);
    push_glyph(OP_PLACE, 0, 0);
    push_glyph(OP_PLACE, 8, 17);
    push_glyph(OP_PLACE, 1023, 1023);
    push_glyph(OP_PLACE, 513, 4);
    push_glyph(OP_PLACE, 1023, 1);
    repeat (MAX_PAGES_DEF + 1) push_glyph(OP_PLACE, PAGE_SIDE_DEF, 16);
    push_glyph(OP_PLACE, 1, 1);
    push_glyph(OP_PLACE, 511, 16);
    push_glyph(OP_CLEAR, 0, 0);
    push_glyph(OP_PLACE, 1, 16);
    push_glyph(OP_PLACE, 511, 1);
    wait_drained();

    // random phases over several shelf heights
    random_phase(1, 200);
    no_gaps = 1'b1;
    random_phase(PAGE_SIDE_DEF, 200);
    no_gaps = 1'b0;
    holds_asked++;
    random_phase(SHELF_H_RST, 200);
    random_phase($urandom_range(2, PAGE_SIDE_DEF - 1), 200);
    random_phase($urandom_range(1, 64), 200);

    if (mismatch_count == 0)
      $display("[glyph_atlas_shelf_packer] OK");
    else
      $display("[glyph_atlas_shelf_packer] ERROR");
    $finish;
  end

  // run limit
  initial begin
    #6000000;
    $display("[glyph_atlas_shelf_packer] ERROR");
    $finish;
  end

endmodule
